// File: design/lcdfb_pkg.sv
// Shared types and constants for the LCD frame store refresh unit.
// Holds transaction structs, opcodes, bus codes and the sequencer microcode ROM.
// No dependencies.
`default_nettype none

package lcdfb_pkg;

  localparam int DEF_PAGES            = 8;
  localparam int DEF_COLUMNS_PER_CHIP = 64;

  localparam logic [7:0] CMD_PAGE   = 8'hB8;
  localparam logic [7:0] CMD_COLUMN = 8'h40;

  localparam logic [1:0] CS_LEFT  = 2'b01;
  localparam logic [1:0] CS_RIGHT = 2'b10;
  localparam logic [1:0] CS_BOTH  = 2'b11;

  typedef enum logic [1:0] {
    OP_STORE   = 2'd0,
    OP_OR      = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_REFRESH = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [2:0] page;
    logic [6:0] column;
    logic [7:0] byte_value;
  } cmd_t;

  typedef struct packed {
    logic       is_data;
    logic [1:0] chip_select;
    logic [7:0] bus_byte;
    logic       frame_end;
  } bus_t;

  // Micro-program addresses
  typedef logic [2:0] step_t;
  localparam step_t ST_FETCH  = 3'd0;
  localparam step_t ST_WRITE  = 3'd1;
  localparam step_t ST_OR_RD  = 3'd2;
  localparam step_t ST_OR_WR  = 3'd3;
  localparam step_t ST_CLEAR  = 3'd4;
  localparam step_t ST_RF_RD  = 3'd5;
  localparam step_t ST_RF_OUT = 3'd6;

  typedef enum logic [1:0] {
    WS_ITEM  = 2'd0,
    WS_MERGE = 2'd1,
    WS_ZERO  = 2'd2
  } wsel_t;

  typedef enum logic [1:0] {
    AS_ITEM    = 2'd0,
    AS_CLEAR   = 2'd1,
    AS_REFRESH = 2'd2
  } asel_t;

  typedef enum logic [1:0] {
    NX_GOTO     = 2'd0,
    NX_DISPATCH = 2'd1,
    NX_CLR_LOOP = 2'd2,
    NX_OUT_WAIT = 2'd3
  } nx_t;

  typedef struct packed {
    logic  take;
    logic  mem_rd;
    logic  mem_we;
    wsel_t wsel;
    asel_t asel;
    logic  load_out;
    logic  clr_step;
    nx_t   nx;
    step_t target;
  } uword_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    w        = '0;
    w.wsel   = WS_ITEM;
    w.asel   = AS_ITEM;
    w.nx     = NX_GOTO;
    w.target = ST_FETCH;
    case (s)
      ST_FETCH: begin
        w.take = 1'b1;
        w.nx   = NX_DISPATCH;
      end
      ST_WRITE: begin
        w.mem_we = 1'b1;
      end
      ST_OR_RD: begin
        w.mem_rd = 1'b1;
        w.target = ST_OR_WR;
      end
      ST_OR_WR: begin
        w.mem_we = 1'b1;
        w.wsel   = WS_MERGE;
      end
      ST_CLEAR: begin
        w.mem_we   = 1'b1;
        w.wsel     = WS_ZERO;
        w.asel     = AS_CLEAR;
        w.clr_step = 1'b1;
        w.nx       = NX_CLR_LOOP;
      end
      ST_RF_RD: begin
        w.mem_rd = 1'b1;
        w.asel   = AS_REFRESH;
        w.target = ST_RF_OUT;
      end
      ST_RF_OUT: begin
        w.asel     = AS_REFRESH;
        w.load_out = 1'b1;
        w.nx       = NX_OUT_WAIT;
      end
      default: begin
        w.target = ST_FETCH;
      end
    endcase
    return w;
  endfunction

  function automatic step_t dispatch(opcode_t op);
    step_t s;
    case (op)
      OP_STORE:   s = ST_WRITE;
      OP_OR:      s = ST_OR_RD;
      OP_CLEAR:   s = ST_CLEAR;
      OP_REFRESH: s = ST_RF_RD;
      default:    s = ST_FETCH;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: design/lcd_framebuffer_refresh_unit.sv
// Frame store and refresh sequencer for a two-chip paged monochrome LCD.
// Micro-programmed control (ROM in lcdfb_pkg) over a single-port byte store.
// Depends on lcdfb_pkg.
//
//  channel | dir | handshake              | payload
//  cmd     | in  | cmd_valid / cmd_ready  | lcdfb_pkg::cmd_t (opcode, page, column, byte_value)
//  bus     | out | bus_valid / bus_ready  | lcdfb_pkg::bus_t (is_data, chip_select, bus_byte, frame_end)
//
// One transaction at a time through one store port: store runs fetch then write, OR runs
// fetch, read then write, refresh runs fetch, read and output plus any wait for the bus register to empty.
// Clear sweeps the store one byte a cycle over all 2**(clog2(PAGES)+clog2(2*COLUMNS_PER_CHIP))
// addresses, 1024 with the defaults.
// Reset runs the same sweep with cmd_ready low.
// A waiting bus transfer does not block store transactions, only the next refresh.
`default_nettype none

module lcd_framebuffer_refresh_unit #(
  parameter int PAGES            = lcdfb_pkg::DEF_PAGES,
  parameter int COLUMNS_PER_CHIP = lcdfb_pkg::DEF_COLUMNS_PER_CHIP
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  wire lcdfb_pkg::cmd_t cmd,
  output logic                 bus_valid,
  input  wire logic            bus_ready,
  output lcdfb_pkg::bus_t      bus
);
  import lcdfb_pkg::*;

  localparam int TOTAL_COLUMNS = 2 * COLUMNS_PER_CHIP;
  localparam int PG_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int COL_W     = $clog2(TOTAL_COLUMNS);
  localparam int SLOT_W    = $clog2(COLUMNS_PER_CHIP + 2);
  localparam int ADDR_W    = PG_W + COL_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  logic [7:0] mem [MEM_DEPTH];

  step_t       step, step_next;
  uword_t      ctl;
  cmd_t        item;
  logic [7:0]  rd_data;
  logic [ADDR_W-1:0] clr_addr;
  logic        clr_last;

  logic              refresh_half, refresh_half_next;
  logic [PG_W-1:0]   refresh_page, refresh_page_next;
  logic [SLOT_W-1:0] refresh_slot, refresh_slot_next;

  logic [COL_W-1:0]  rf_col;
  logic [ADDR_W-1:0] addr;
  logic [7:0]        wdata;
  logic              item_inside;
  logic              we;
  logic              out_free;
  logic              load;
  bus_t              xfer;
  logic              last_col, last_page;

  assign ctl       = ucode(step);
  assign cmd_ready = ctl.take;
  assign out_free  = !bus_valid || bus_ready;
  assign load      = ctl.load_out && out_free;
  assign clr_last  = &clr_addr;

  assign item_inside = (4'(item.page) < 4'(PAGES)) && (8'(item.column) < 8'(TOTAL_COLUMNS));

  // slot 2 holds the first data column of the half
  assign rf_col = COL_W'(refresh_slot) - COL_W'(2)
                + (refresh_half ? COL_W'(COLUMNS_PER_CHIP) : COL_W'(0));

  always_comb begin
    case (ctl.asel)
      AS_ITEM:    addr = {item.page[PG_W-1:0], item.column[COL_W-1:0]};
      AS_CLEAR:   addr = clr_addr;
      AS_REFRESH: addr = {refresh_page, rf_col};
      default:    addr = clr_addr;
    endcase
    case (ctl.wsel)
      WS_ITEM:  wdata = item.byte_value;
      WS_MERGE: wdata = rd_data | item.byte_value;
      WS_ZERO:  wdata = 8'd0;
      default:  wdata = 8'd0;
    endcase
    we = ctl.mem_we && (ctl.asel != AS_ITEM || item_inside);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mem_rd) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      item <= cmd;
    end
  end

  // Refresh transfer and next position
  always_comb begin
    last_col  = refresh_slot == SLOT_W'(COLUMNS_PER_CHIP + 1);
    last_page = refresh_page == PG_W'(PAGES - 1);
    refresh_half_next = refresh_half;
    refresh_page_next = refresh_page;
    refresh_slot_next = refresh_slot;
    xfer = '0;
    if (refresh_slot == SLOT_W'(0)) begin
      xfer.chip_select  = CS_BOTH;
      xfer.bus_byte     = CMD_COLUMN;
      refresh_slot_next = SLOT_W'(1);
    end else if (refresh_slot == SLOT_W'(1)) begin
      xfer.chip_select  = CS_BOTH;
      xfer.bus_byte     = CMD_PAGE | 8'(refresh_page);
      refresh_slot_next = SLOT_W'(2);
    end else begin
      xfer.is_data     = 1'b1;
      xfer.chip_select = refresh_half ? CS_RIGHT : CS_LEFT;
      xfer.bus_byte    = rd_data;
      xfer.frame_end   = refresh_half && last_col && last_page;
      if (!last_col) begin
        refresh_slot_next = refresh_slot + SLOT_W'(1);
      end else if (!last_page) begin
        refresh_page_next = refresh_page + PG_W'(1);
        // left-half pages after the first skip the column command
        refresh_slot_next = refresh_half ? SLOT_W'(0) : SLOT_W'(1);
      end else begin
        refresh_half_next = !refresh_half;
        refresh_page_next = '0;
        refresh_slot_next = '0;
      end
    end
  end

  always_comb begin
    case (ctl.nx)
      NX_GOTO:     step_next = ctl.target;
      NX_DISPATCH: step_next = cmd_valid ? dispatch(cmd.opcode) : step;
      NX_CLR_LOOP: step_next = clr_last ? ctl.target : step;
      NX_OUT_WAIT: step_next = out_free ? ctl.target : step;
      default:     step_next = ST_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= ST_CLEAR;
      clr_addr     <= '0;
      refresh_half <= 1'b0;
      refresh_page <= '0;
      refresh_slot <= '0;
      bus_valid    <= 1'b0;
    end else begin
      step <= step_next;
      if (ctl.clr_step) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (load) begin
        refresh_half <= refresh_half_next;
        refresh_page <= refresh_page_next;
        refresh_slot <= refresh_slot_next;
        bus_valid    <= 1'b1;
      end else if (bus_ready) begin
        bus_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bus <= xfer;
    end
  end

endmodule

`default_nettype wire

// File: design/lcdfb_checker.sv
// Port-level checks for lcd_framebuffer_refresh_unit, attached by bind below.
// Depends on lcdfb_pkg.
`default_nettype none

module lcdfb_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            cmd_valid,
  input wire logic            cmd_ready,
  input wire lcdfb_pkg::cmd_t cmd,
  input wire logic            bus_valid,
  input wire logic            bus_ready,
  input wire lcdfb_pkg::bus_t bus
);
  import lcdfb_pkg::*;

  // reset starts the clearing sweep with nothing on the bus
  a_reset_quiet: assert property (@(posedge clk) rst |=> !cmd_ready && !bus_valid)
    else $error("ready or bus valid straight after reset");

  a_bus_hold: assert property (@(posedge clk) disable iff (rst)
    bus_valid && !bus_ready |=> bus_valid && $stable(bus))
    else $error("stalled bus transaction changed");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd.opcode != OP_REFRESH && !bus_valid |=> !bus_valid)
    else $error("bus transaction from a store operation");

  a_refresh_latency: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && cmd.opcode == OP_REFRESH && !bus_valid |-> ##3 bus_valid)
    else $error("refresh transaction late");

  a_chip_select: assert property (@(posedge clk) disable iff (rst)
    bus_valid |-> (bus.is_data ? (bus.chip_select == CS_LEFT || bus.chip_select == CS_RIGHT)
                               : (bus.chip_select == CS_BOTH && !bus.frame_end))
                  && (!bus.frame_end || bus.chip_select == CS_RIGHT))
    else $error("chip select does not match transfer kind");

endmodule

bind lcd_framebuffer_refresh_unit lcdfb_checker u_lcdfb_checker (.*);

`default_nettype wire

// File: tb/lcdfb_refresh_checker.sv
// Bus checker for the LCD frame store refresh unit: mirrors the pixel store and the
// refresh position from accepted commands and checks every bus transaction in order.
// Depends on lcdfb_pkg.
`default_nettype none

module lcdfb_refresh_checker (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  input  wire logic            cmd_ready,
  input  wire lcdfb_pkg::cmd_t cmd,
  input  wire logic            bus_valid,
  input  wire logic            bus_ready,
  input  wire lcdfb_pkg::bus_t bus,
  output int                   errors,
  output int                   pending,
  output int                   transfers_checked,
  output int                   frames_seen
);
  import lcdfb_pkg::*;

  localparam int PAGES      = DEF_PAGES;
  localparam int COLS       = DEF_COLUMNS_PER_CHIP;
  localparam int TOTAL_COLS = 2 * COLS;

  logic [7:0] pixel_mirror [PAGES][TOTAL_COLS];
  logic       rf_half;
  logic [2:0] rf_page;
  logic [6:0] rf_slot;
  bus_t       expected_transfers [$];

  task automatic wipe_mirror();
    for (int p = 0; p < PAGES; p++)
      for (int c = 0; c < TOTAL_COLS; c++)
        pixel_mirror[p][c] = 8'h00;
  endtask

  // Slot 0 column command, slot 1 page command, slots 2.. data bytes.
  task automatic predict_transfer(output bus_t t);
    int   col;
    logic last_col;
    logic last_page;
    t = '0;
    if (rf_slot == 0) begin
      t.chip_select = CS_BOTH;
      t.bus_byte    = CMD_COLUMN;
      rf_slot       = 1;
    end else if (rf_slot == 1) begin
      t.chip_select = CS_BOTH;
      t.bus_byte    = CMD_PAGE | {5'd0, rf_page};
      rf_slot       = 2;
    end else begin
      col           = int'(rf_slot) - 2 + (rf_half ? COLS : 0);
      last_col      = (int'(rf_slot) == COLS + 1);
      last_page     = (int'(rf_page) == PAGES - 1);
      t.is_data     = 1'b1;
      t.chip_select = rf_half ? CS_RIGHT : CS_LEFT;
      t.bus_byte    = pixel_mirror[rf_page][col];
      t.frame_end   = rf_half && last_col && last_page;
      if (!last_col) begin
        rf_slot = rf_slot + 7'd1;
      end else if (!last_page) begin
        rf_page = rf_page + 3'd1;
        // left-half pages after the first skip the column command
        rf_slot = rf_half ? 7'd0 : 7'd1;
      end else begin
        rf_half = ~rf_half;
        rf_page = 3'd0;
        rf_slot = 7'd0;
      end
    end
  endtask

  task automatic check_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      errors++;
      $display("%0t: bus %s mismatch, expected 0x%0h, got 0x%0h",
               $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : watch
    bus_t want;
    if (rst) begin
      wipe_mirror();
      rf_half = 1'b0;
      rf_page = 3'd0;
      rf_slot = 7'd0;
      expected_transfers.delete();
    end else begin
      // results leaving now belong to earlier refreshes, so compare before predicting
      if (bus_valid && bus_ready) begin
        if (expected_transfers.size() == 0) begin
          errors++;
          $display("%0t: unexpected bus transaction, expected none, got %0h",
                   $time, bus);
        end else begin
          want = expected_transfers.pop_front();
          check_field("is_data", want.is_data, bus.is_data);
          check_field("chip_select", want.chip_select, bus.chip_select);
          check_field("bus_byte", want.bus_byte, bus.bus_byte);
          check_field("frame_end", want.frame_end, bus.frame_end);
          transfers_checked++;
          if (want.frame_end) frames_seen++;
        end
      end
      if (cmd_valid && cmd_ready) begin
        case (cmd.opcode)
          OP_STORE: begin
            if (int'(cmd.page) < PAGES && int'(cmd.column) < TOTAL_COLS)
              pixel_mirror[cmd.page][cmd.column] = cmd.byte_value;
          end
          OP_OR: begin
            if (int'(cmd.page) < PAGES && int'(cmd.column) < TOTAL_COLS)
              pixel_mirror[cmd.page][cmd.column] =
                pixel_mirror[cmd.page][cmd.column] | cmd.byte_value;
          end
          OP_CLEAR: wipe_mirror();
          OP_REFRESH: begin
            predict_transfer(want);
            expected_transfers.push_back(want);
          end
          default: ;
        endcase
      end
    end
    pending = expected_transfers.size();
  end

endmodule

`default_nettype wire

// File: tb/lcd_framebuffer_refresh_unit_test.sv
// Testbench top for lcd_framebuffer_refresh_unit: clock, reset, command stimulus,
// bus back-pressure, watchdog and verdict. Checking lives in lcdfb_refresh_checker.
// Depends on lcdfb_pkg, lcd_framebuffer_refresh_unit and lcdfb_refresh_checker.
`default_nettype none

module lcd_framebuffer_refresh_unit_test;
  import lcdfb_pkg::*;

  localparam int PAGES          = DEF_PAGES;
  localparam int COLS           = DEF_COLUMNS_PER_CHIP;
  localparam int LEFT_LEN       = 1 + PAGES * (COLS + 1);
  localparam int FRAME_LEN      = LEFT_LEN + PAGES * (COLS + 2);
  localparam int PHASE_ITEMS    = 410;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic bus_ready = 1'b0;
  cmd_t cmd       = '0;
  logic cmd_ready;
  logic bus_valid;
  bus_t bus;

  int fail_count;
  int pending;
  int transfers_checked;
  int frames_seen;
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int items_sent         = 0;
  int refreshes_sent     = 0;
  int quiet_cycles       = 0;

  always #5 clk = ~clk;

  lcd_framebuffer_refresh_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .bus_valid (bus_valid),
    .bus_ready (bus_ready),
    .bus       (bus)
  );

  lcdfb_refresh_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .cmd_valid         (cmd_valid),
    .cmd_ready         (cmd_ready),
    .cmd               (cmd),
    .bus_valid         (bus_valid),
    .bus_ready         (bus_ready),
    .bus               (bus),
    .errors            (fail_count),
    .pending           (pending),
    .transfers_checked (transfers_checked),
    .frames_seen       (frames_seen)
  );

  always @(negedge clk) begin
    bus_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (bus_valid && bus_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d bus transactions outstanding", $time, pending);
      $display("lcd_framebuffer_refresh_unit test failed");
      $finish;
    end
  end

  function automatic cmd_t pack_item(opcode_t op, logic [2:0] pg, logic [6:0] col,
                                     logic [7:0] val);
    cmd_t c;
    c.opcode     = op;
    c.page       = pg;
    c.column     = col;
    c.byte_value = val;
    return c;
  endfunction

  // Store address read by refresh number pos of a frame; 0 for command slots.
  function automatic bit frame_address(int pos, output logic [2:0] pg,
                                       output logic [6:0] col);
    int q;
    pg  = 3'd0;
    col = 7'd0;
    if (pos == 0) return 1'b0;
    if (pos < LEFT_LEN) begin
      q   = pos - 1;
      pg  = 3'(q / (COLS + 1));
      col = 7'((q % (COLS + 1)) - 1);
      return (q % (COLS + 1)) != 0;
    end
    q   = pos - LEFT_LEN;
    pg  = 3'(q / (COLS + 2));
    col = 7'(COLS + (q % (COLS + 2)) - 2);
    return (q % (COLS + 2)) >= 2;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(cmd_t c);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (c.opcode == OP_REFRESH) refreshes_sent++;
  endtask

  task automatic send_random_item();
    cmd_t       c;
    int         r;
    logic [2:0] pg;
    logic [6:0] col;
    r = $urandom_range(99);
    c = pack_item(OP_REFRESH, 3'($urandom_range(7)), 7'($urandom_range(127)),
                  8'($urandom_range(255)));
    if (r >= 72) begin
      c.opcode = (r < 91) ? OP_STORE : (r < 99) ? OP_OR : OP_CLEAR;
      // aim half the writes just ahead of the refresh so the bus shows them
      if ($urandom_range(1) == 1 &&
          frame_address((refreshes_sent + $urandom_range(1, 80)) % FRAME_LEN, pg, col)) begin
        c.page   = pg;
        c.column = col;
      end
    end
    send_item(c);
  endtask

  task automatic wait_for_bus_drain();
    cmd_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (PHASE_ITEMS) send_random_item();
    wait_for_bus_drain();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: frame start, replace and merge, extremes, clear mid-frame
    send_item(pack_item(OP_REFRESH, 3'd7, 7'd127, 8'hFF));
    send_item(pack_item(OP_REFRESH, 3'd0, 7'd0, 8'h00));
    send_item(pack_item(OP_STORE, 3'd0, 7'd0, 8'hA5));
    send_item(pack_item(OP_REFRESH, 3'd0, 7'd0, 8'h00));
    send_item(pack_item(OP_STORE, 3'd0, 7'd1, 8'h5A));
    send_item(pack_item(OP_OR, 3'd0, 7'd1, 8'h81));
    send_item(pack_item(OP_REFRESH, 3'd5, 7'd42, 8'h3C));
    send_item(pack_item(OP_STORE, 3'd7, 7'd127, 8'hFF));
    send_item(pack_item(OP_OR, 3'd7, 7'd127, 8'h00));
    send_item(pack_item(OP_STORE, 3'd0, 7'd127, 8'h80));
    send_item(pack_item(OP_STORE, 3'd7, 7'd0, 8'h01));
    send_item(pack_item(OP_OR, 3'd0, 7'd2, 8'hFF));
    send_item(pack_item(OP_CLEAR, 3'd7, 7'd127, 8'hFF));
    send_item(pack_item(OP_REFRESH, 3'd0, 7'd0, 8'h00));
    send_item(pack_item(OP_OR, 3'd0, 7'd3, 8'h7E));
    send_item(pack_item(OP_REFRESH, 3'd0, 7'd0, 8'h00));
    send_item(pack_item(OP_STORE, 3'd0, 7'd4, 8'hFF));
    send_item(pack_item(OP_REFRESH, 3'd0, 7'd0, 8'h00));
    wait_for_bus_drain();

    run_phase(0, 0);
    run_phase(73, 0);
    run_phase(0, 73);
    run_phase(28, 28);

    receiver_stall_pct = 0;
    wait_for_bus_drain();
    repeat (50) @(negedge clk);

    $display("Sent %0d commands, %0d of them refresh requests, under four idle/stall mixes.",
             items_sent, refreshes_sent);
    $display("Checked %0d bus transactions spanning %0d complete frames.",
             transfers_checked, frames_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("lcd_framebuffer_refresh_unit test passed");
    end else begin
      $display("lcd_framebuffer_refresh_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
design/lcdfb_pkg.sv
design/lcd_framebuffer_refresh_unit.sv
design/lcdfb_checker.sv
tb/lcdfb_refresh_checker.sv
tb/lcd_framebuffer_refresh_unit_test.sv
